// File: design/prou_pkg.sv
// Shared types, constants and color functions of the pixel raster unit
`default_nettype none
package prou_pkg;

    // Widths fixed by the item fields
    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int CNT_W   = 11;
    localparam int PROD_W  = 23;
    localparam int OFF_W   = 25;

    localparam int STORE_BYTES_DEF = 131072;
    localparam int QUEUE_DEPTH     = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_16BIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_KEY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCISSOR      = 3'd7;

    localparam logic [63:0] SCISSOR_RESET = 64'hFFFF_FFFF_0000_0000;

    // Commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FILL  = 1'b1;

    // Dither and raster operation codes
    localparam logic [1:0] DITHER_OFF = 2'd0;
    localparam logic [1:0] DITHER_2X2 = 2'd1;
    localparam logic [1:0] ROP_COPY   = 2'd0;
    localparam logic [1:0] ROP_XOR    = 2'd1;
    localparam logic [1:0] ROP_OR     = 2'd2;
    localparam logic [1:0] ROP_AND    = 2'd3;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_SCISSOR = 2'd2,
        ST_KEYED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_FILL
    } back_state_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [11:0] row_stride;
        logic        pixel_16bit;
        logic [16:0] chroma_key;
        logic [1:0]  dither_select;
        logic [1:0]  blend_select;
        logic [63:0] scissor_rect;
    } cfg_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic               cmd;
        status_t            status;
        logic [OFF_W-1:0]   base;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] color;
    } op_t;

    // Bayer thresholds, indexed by {y, x}
    localparam logic [1:0] BAYER2 [4]  = '{2'd0, 2'd2, 2'd3, 2'd1};
    localparam logic [3:0] BAYER4 [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // Per channel biased add with saturation
    function automatic logic [15:0] dither_px(input logic [15:0] c, input logic p16,
                                              input logic [3:0] bv);
        logic [5:0] rs;
        logic [6:0] gs;
        logic [5:0] bs;
        logic [3:0] r8;
        logic [3:0] g8;
        logic [2:0] b8;
        logic [15:0] res;
        rs = {1'b0, c[15:11]} + {5'd0, bv[3]};
        gs = {1'b0, c[10:5]} + {5'd0, bv[3:2]};
        bs = {1'b0, c[4:0]} + {5'd0, bv[3]};
        r8 = {1'b0, c[7:5]} + {1'b0, bv[3:1]};
        g8 = {1'b0, c[4:2]} + {1'b0, bv[3:1]};
        b8 = {1'b0, c[1:0]} + {2'd0, bv[3]};
        if (p16)
        begin
            res = {(rs >= 6'd31) ? 5'd31 : rs[4:0],
                   (gs >= 7'd63) ? 6'd63 : gs[5:0],
                   (bs >= 6'd31) ? 5'd31 : bs[4:0]};
        end
        else
        begin
            res = {8'd0,
                   (r8 >= 4'd7) ? 3'd7 : r8[2:0],
                   (g8 >= 4'd7) ? 3'd7 : g8[2:0],
                   (b8 >= 3'd3) ? 2'd3 : b8[1:0]};
        end
        return res;
    endfunction

    function automatic logic [15:0] blend_op(input logic [1:0] sel, input logic [15:0] src,
                                             input logic [15:0] old);
        logic [15:0] res;
        case (sel)
            ROP_XOR: res = src ^ old;
            ROP_OR:  res = src | old;
            ROP_AND: res = src & old;
            default: res = src;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/prou_ram.sv
// Generic single port RAM with registered read
`default_nettype none
module prou_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: design/prou_queue.sv
// Short queue of classified operations between front and back
`default_nettype none
module prou_queue
    import prou_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_data,
    output logic      full,
    input  wire logic pop,
    output op_t       pop_data,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: design/prou_front.sv
// Front end: accepts items, clips, keys, dithers and computes store offsets
`default_nettype none
module prou_front
    import prou_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfg_t                       cfg,
    input  wire logic                       hold,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       command,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic signed [COORD_W-1:0]  span_end_x,
    input  wire logic        [COLOR_W-1:0]  pixel_color,
    input  wire logic                       q_full,
    output logic                            q_push,
    output op_t                             q_data
);

    logic signed [16:0] xs, ys, xes, fw_s, fh_s;
    logic signed [16:0] sxmin, symin, sxmax, symax;
    logic signed [16:0] x0c, x1c, x0s, x1s;
    logic               px_out, px_scis, px_key, fl_out, fl_scis;
    logic [3:0]         bv;
    logic [11:0]        mop;
    status_t            status_a;
    logic [CNT_W-1:0]   x0_a, x1_a;
    logic [COLOR_W-1:0] color_a;
    logic               accept;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_cmd_reg;
    status_t            s1_status_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [CNT_W-1:0]   s1_x0_reg, s1_x1_reg;
    logic [COLOR_W-1:0] s1_color_reg;

    logic [OFF_W-2:0]   end_lin, base_lin;
    logic [OFF_W-1:0]   end_off;
    logic               beyond;

    assign in_stall = hold || (s1_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;

    // Signed coordinate views
    assign xs    = 17'(pos_x);
    assign ys    = 17'(pos_y);
    assign xes   = 17'(span_end_x);
    assign fw_s  = $signed({6'd0, cfg.frame_width});
    assign fh_s  = $signed({6'd0, cfg.frame_height});
    assign sxmin = $signed({1'b0, cfg.scissor_rect[15:0]});
    assign symin = $signed({1'b0, cfg.scissor_rect[31:16]});
    assign sxmax = $signed({1'b0, cfg.scissor_rect[47:32]});
    assign symax = $signed({1'b0, cfg.scissor_rect[63:48]});

    // Pixel gates
    assign px_out  = (xs < 0) || (ys < 0) || (xs >= fw_s) || (ys >= fh_s);
    assign px_scis = (xs < sxmin) || (xs > sxmax) || (ys < symin) || (ys > symax);
    assign px_key  = cfg.chroma_key[16] &&
                     (cfg.pixel_16bit ? (pixel_color == cfg.chroma_key[15:0])
                                      : (pixel_color[7:0] == cfg.chroma_key[7:0]));

    // Span clipping to frame then scissor
    assign x0c     = (xs < 0) ? 17'sd0 : xs;
    assign x1c     = (xes >= fw_s) ? (fw_s - 17'sd1) : xes;
    assign fl_out  = (ys < 0) || (ys >= fh_s) || (x0c > x1c);
    assign x0s     = (x0c < sxmin) ? sxmin : x0c;
    assign x1s     = (x1c > sxmax) ? sxmax : x1c;
    assign fl_scis = (ys < symin) || (ys > symax) || (x0s > x1s);

    // Dither threshold
    assign bv = (cfg.dither_select == DITHER_2X2) ? {BAYER2[{pos_y[0], pos_x[0]}], 2'b00}
                                                  : BAYER4[{pos_y[1:0], pos_x[1:0]}];

    // Classification, color and coordinates of the accepted item
    always_comb
    begin
        status_a = ST_WRITTEN;
        x0_a     = xs[CNT_W-1:0];
        x1_a     = xs[CNT_W-1:0];
        color_a  = pixel_color;
        if (command == CMD_PIXEL)
        begin
            if (px_out)
            begin
                status_a = ST_OUTSIDE;
            end
            else if (px_scis)
            begin
                status_a = ST_SCISSOR;
            end
            else if (px_key)
            begin
                status_a = ST_KEYED;
            end
            if (cfg.dither_select != DITHER_OFF)
            begin
                color_a = dither_px(pixel_color, cfg.pixel_16bit, bv);
            end
        end
        else
        begin
            x0_a = x0s[CNT_W-1:0];
            x1_a = x1s[CNT_W-1:0];
            if (fl_out)
            begin
                status_a = ST_OUTSIDE;
            end
            else if (fl_scis)
            begin
                status_a = ST_SCISSOR;
            end
        end
        if (!cfg.pixel_16bit)
        begin
            color_a = {8'd0, color_a[7:0]};
        end
    end

    assign mop = cfg.pixel_16bit ? {1'b0, cfg.frame_width} : cfg.row_stride;

    // Stage one valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Row product and item fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= command;
            s1_status_reg <= status_a;
            s1_prod_reg   <= ys[10:0] * mop;
            s1_x0_reg     <= x0_a;
            s1_x1_reg     <= x1_a;
            s1_color_reg  <= color_a;
        end
    end

    // Store offset and range check of the last byte touched
    assign end_lin  = {1'b0, s1_prod_reg} + {13'd0, s1_x1_reg};
    assign base_lin = {1'b0, s1_prod_reg} + {13'd0, s1_x0_reg};
    assign end_off  = cfg.pixel_16bit ? {end_lin, 1'b1} : {1'b0, end_lin};
    assign beyond   = (end_off >= OFF_W'(STORE_BYTES));

    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        q_data.cmd    = s1_cmd_reg;
        q_data.base   = cfg.pixel_16bit ? {base_lin, 1'b0} : {1'b0, base_lin};
        q_data.count  = s1_x1_reg - s1_x0_reg + 1'b1;
        q_data.color  = s1_color_reg;
        q_data.status = s1_status_reg;
        if (s1_status_reg == ST_WRITTEN && beyond)
        begin
            q_data.status = ST_OUTSIDE;
        end
    end

endmodule
`default_nettype wire

// File: design/prou_back.sv
// Back end: clears the store, performs blends and span fills, holds results
`default_nettype none
module prou_back
    import prou_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               q_empty,
    input  wire op_t                q_data,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [COLOR_W-1:0]      stored_value,
    output logic [CNT_W-1:0]        pixels_written
);

    localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int AW         = $clog2(BANK_DEPTH);

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [OFF_W-1:0]   cur_off_reg, cur_off_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    op_t                op_reg;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [COLOR_W-1:0] out_value_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               out_free;
    logic               load;
    status_t            load_status;
    logic [COLOR_W-1:0] load_value;
    logic [CNT_W-1:0]   load_count;
    logic [AW-1:0]      ram_addr;
    logic               lo_we, hi_we;
    logic [7:0]         lo_wdata, hi_wdata, lo_rdata, hi_rdata;
    logic [COLOR_W-1:0] old_px, blend_res;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty && out_free;
    assign clearing = (state_reg == B_CLEAR);

    assign old_px    = cfg.pixel_16bit ? {hi_rdata, lo_rdata}
                                       : {8'd0, op_reg.base[0] ? hi_rdata : lo_rdata};
    assign blend_res = blend_op(cfg.blend_select, op_reg.color, old_px);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == AW'(BANK_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_pop && q_data.status == ST_WRITTEN)
                begin
                    state_next = (q_data.cmd == CMD_PIXEL) ? B_READ : B_FILL;
                end
            end
            B_READ:
            begin
                state_next = B_IDLE;
            end
            B_FILL:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Memory control and result load
    always_comb
    begin
        ram_addr    = cur_off_reg[AW:1];
        lo_we       = 1'b0;
        hi_we       = 1'b0;
        lo_wdata    = '0;
        hi_wdata    = '0;
        load        = 1'b0;
        load_status = ST_WRITTEN;
        load_value  = '0;
        load_count  = '0;
        case (state_reg)
            B_CLEAR:
            begin
                ram_addr = clr_addr_reg;
                lo_we    = 1'b1;
                hi_we    = 1'b1;
            end
            B_IDLE:
            begin
                ram_addr = q_data.base[AW:1];
                if (q_pop && q_data.status != ST_WRITTEN)
                begin
                    load        = 1'b1;
                    load_status = q_data.status;
                end
            end
            B_READ:
            begin
                lo_wdata   = blend_res[7:0];
                hi_wdata   = cfg.pixel_16bit ? blend_res[15:8] : blend_res[7:0];
                lo_we      = cfg.pixel_16bit || !cur_off_reg[0];
                hi_we      = cfg.pixel_16bit || cur_off_reg[0];
                load       = 1'b1;
                load_value = blend_res;
                load_count = CNT_W'(1);
            end
            B_FILL:
            begin
                lo_wdata = op_reg.color[7:0];
                hi_wdata = cfg.pixel_16bit ? op_reg.color[15:8] : op_reg.color[7:0];
                lo_we    = cfg.pixel_16bit || !cur_off_reg[0];
                hi_we    = cfg.pixel_16bit || cur_off_reg[0];
                if (left_reg == CNT_W'(1))
                begin
                    load       = 1'b1;
                    load_value = op_reg.color;
                    load_count = op_reg.count;
                end
            end
            default:
            begin
                ram_addr = cur_off_reg[AW:1];
            end
        endcase
    end

    // Counters and result valid
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        cur_off_next   = cur_off_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == B_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (q_pop)
        begin
            cur_off_next = q_data.base;
            left_next    = q_data.count;
        end
        else if (state_reg == B_FILL)
        begin
            cur_off_next = cur_off_reg + (cfg.pixel_16bit ? OFF_W'(2) : OFF_W'(1));
            left_next    = left_reg - 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_off_reg <= cur_off_next;
        left_reg    <= left_next;
        if (q_pop)
        begin
            op_reg <= q_data;
        end
        if (load)
        begin
            out_status_reg <= load_status;
            out_value_reg  <= load_value;
            out_count_reg  <= load_count;
        end
    end

    // Even and odd byte banks
    prou_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_lo_bank
    (
        .clk   (clk),
        .we    (lo_we),
        .addr  (ram_addr),
        .wdata (lo_wdata),
        .rdata (lo_rdata)
    );

    prou_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_hi_bank
    (
        .clk   (clk),
        .we    (hi_we),
        .addr  (ram_addr),
        .wdata (hi_wdata),
        .rdata (hi_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign stored_value   = out_value_reg;
    assign pixels_written = out_count_reg;

    // No item leaves the queue during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !q_pop)
        else $error("queue popped during store clear");

    // A pending read-modify-write must find the result register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_READ |-> !out_valid_reg)
        else $error("result register busy at pixel write");

    // Fills only run with pixels left and inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_FILL |-> (left_reg != '0) && (cur_off_reg < OFF_W'(STORE_BYTES)))
        else $error("span fill out of range");

endmodule
`default_nettype wire

// File: design/pixel_raster_op_unit.sv
// Top level of the pixel raster unit: configuration registers, front, queue, back
//
// Input channel (in_valid/in_stall) takes one item per handshake: a pixel write or a
// horizontal span fill. Output channel (out_valid/out_stall) returns one result item
// per input item, in order: status, stored value and number of pixels stored.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be written
// while idle; the block itself does not enforce this. out_valid rises once an item has
// passed the front stage register, the queue and the back end. The back end answers a
// rejected item in its idle state, does a pixel write as a registered store read, then
// blend and write back, and fills a span one pixel at a time after the pop; the store's
// single port per bank sets this pace. The front end takes one item per cycle while
// in_stall is low, into a two entry queue, so short stalls on either side are absorbed.
// After reset a clearing pass writes zero over the (STORE_BYTES+1)/2 words of the store
// (65536 at the default size), one 16-bit word per cycle; in_stall is high meanwhile.
// While out_stall is high the result register holds; the back end stops at the next
// item and the queue and front end then fill up and raise in_stall.
`default_nettype none
module pixel_raster_op_unit
    import prou_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [63:0]                cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       command,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic signed [COORD_W-1:0]  span_end_x,
    input  wire logic        [COLOR_W-1:0]  pixel_color,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      status,
    output logic [COLOR_W-1:0]              stored_value,
    output logic [CNT_W-1:0]                pixels_written
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_empty, q_push, q_pop, clearing;
    op_t  q_in, q_out;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_next.frame_width   = cfg_data[10:0];
                CFG_FRAME_HEIGHT: cfg_next.frame_height  = cfg_data[10:0];
                CFG_ROW_STRIDE:   cfg_next.row_stride    = cfg_data[11:0];
                CFG_PIXEL_16BIT:  cfg_next.pixel_16bit   = cfg_data[0];
                CFG_CHROMA_KEY:   cfg_next.chroma_key    = cfg_data[16:0];
                CFG_DITHER:       cfg_next.dither_select = cfg_data[1:0];
                CFG_BLEND:        cfg_next.blend_select  = cfg_data[1:0];
                CFG_SCISSOR:      cfg_next.scissor_rect  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{scissor_rect: SCISSOR_RESET, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prou_front #(.STORE_BYTES(STORE_BYTES)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .hold        (clearing),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .span_end_x  (span_end_x),
        .pixel_color (pixel_color),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    prou_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    prou_back #(.STORE_BYTES(STORE_BYTES)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .stored_value   (stored_value),
        .pixels_written (pixels_written)
    );

endmodule
`default_nettype wire

// File: tb/sv/pixel_raster_op_checker.sv
// Checker for the pixel raster unit: predicts each result item and compares it
`timescale 1ns / 100ps
`default_nettype none
module pixel_raster_op_checker
    import prou_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [63:0]               cfg_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic                      command,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic signed [COORD_W-1:0] span_end_x,
    input  wire logic [COLOR_W-1:0]        pixel_color,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic [1:0]                status,
    input  wire logic [COLOR_W-1:0]        stored_value,
    input  wire logic [CNT_W-1:0]          pixels_written,
    output int                             mismatches,
    output int                             pending
);

    typedef struct packed {
        logic [1:0]         st;
        logic [COLOR_W-1:0] val;
        logic [CNT_W-1:0]   cnt;
    } raster_result_t;

    raster_result_t expected_q[$];
    logic [7:0]     frame_mem [STORE_BYTES_DEF];

    // Shadow copy of the configuration registers
    logic [10:0] m_width;
    logic [10:0] m_height;
    logic [11:0] m_stride;
    logic        m_p16;
    logic [16:0] m_key;
    logic [1:0]  m_dither;
    logic [1:0]  m_blend;
    logic [63:0] m_scissor;

    function automatic int sat(input int v, input int maxv);
        return (v >= maxv) ? maxv : v;
    endfunction

    // Ordered dither of one color at pixel (ux, uy)
    function automatic logic [15:0] dither_color(input logic [15:0] c, input int ux, input int uy);
        int bv;
        int r;
        int g;
        int b;
        if (m_dither == DITHER_2X2)
            bv = int'(BAYER2[{uy[0], ux[0]}]) << 2;
        else
            bv = int'(BAYER4[{uy[1:0], ux[1:0]}]);
        if (m_p16)
        begin
            r = sat(int'(c[15:11]) + (bv >> 3), 31);
            g = sat(int'(c[10:5]) + (bv >> 2), 63);
            b = sat(int'(c[4:0]) + (bv >> 3), 31);
            return {r[4:0], g[5:0], b[4:0]};
        end
        r = sat(int'(c[7:5]) + (bv >> 1), 7);
        g = sat(int'(c[4:2]) + (bv >> 1), 7);
        b = sat(int'(c[1:0]) + ((bv >= 8) ? 1 : 0), 3);
        return {8'd0, r[2:0], g[2:0], b[1:0]};
    endfunction

    function automatic logic [15:0] combine(input logic [15:0] src, input logic [15:0] old);
        case (m_blend)
            ROP_XOR: return src ^ old;
            ROP_OR:  return src | old;
            ROP_AND: return src & old;
            default: return src;
        endcase
    endfunction

    // Expected result of one item; updates the shadow store
    function automatic raster_result_t predict_raster(input logic cmd, input int x, input int y,
                                                      input int xe, input logic [15:0] color);
        raster_result_t res;
        int w;
        int h;
        int sxmin;
        int symin;
        int sxmax;
        int symax;
        int x0;
        int x1;
        int n;
        longint off;
        logic [15:0] c;
        logic [15:0] old;
        w = int'(m_width);
        h = int'(m_height);
        sxmin = int'(m_scissor[15:0]);
        symin = int'(m_scissor[31:16]);
        sxmax = int'(m_scissor[47:32]);
        symax = int'(m_scissor[63:48]);
        res = '{st: ST_WRITTEN, val: '0, cnt: '0};
        c = color;
        if (cmd == CMD_PIXEL)
        begin
            if (x < 0 || y < 0 || x >= w || y >= h)
                res.st = ST_OUTSIDE;
            else if (x < sxmin || x > sxmax || y < symin || y > symax)
                res.st = ST_SCISSOR;
            else if (m_key[16] && (m_p16 ? (c == m_key[15:0]) : (c[7:0] == m_key[7:0])))
                res.st = ST_KEYED;
            else
            begin
                if (m_dither != DITHER_OFF)
                    c = dither_color(m_p16 ? c : {8'd0, c[7:0]}, x, y);
                if (!m_p16)
                begin
                    off = longint'(y) * longint'(m_stride) + x;
                    if (off >= STORE_BYTES_DEF)
                        res.st = ST_OUTSIDE;
                    else
                    begin
                        res.val = combine({8'd0, c[7:0]}, {8'd0, frame_mem[off]});
                        frame_mem[off] = res.val[7:0];
                        res.cnt = 1;
                    end
                end
                else
                begin
                    off = 2 * (longint'(y) * w + x);
                    if (off + 1 >= STORE_BYTES_DEF)
                        res.st = ST_OUTSIDE;
                    else
                    begin
                        old = {frame_mem[off + 1], frame_mem[off]};
                        res.val = combine(c, old);
                        frame_mem[off] = res.val[7:0];
                        frame_mem[off + 1] = res.val[15:8];
                        res.cnt = 1;
                    end
                end
            end
        end
        else
        begin
            x0 = (x < 0) ? 0 : x;
            x1 = (xe >= w) ? w - 1 : xe;
            if (y < 0 || y >= h || x0 > x1)
                res.st = ST_OUTSIDE;
            else
            begin
                if (x0 < sxmin) x0 = sxmin;
                if (x1 > sxmax) x1 = sxmax;
                if (y < symin || y > symax || x0 > x1)
                    res.st = ST_SCISSOR;
                else
                begin
                    n = x1 - x0 + 1;
                    if (!m_p16)
                    begin
                        off = longint'(y) * longint'(m_stride) + x0;
                        if (off + n - 1 >= STORE_BYTES_DEF)
                            res.st = ST_OUTSIDE;
                        else
                        begin
                            res.val = {8'd0, c[7:0]};
                            for (int i = 0; i < n; i++) frame_mem[off + i] = c[7:0];
                            res.cnt = n[CNT_W-1:0];
                        end
                    end
                    else
                    begin
                        off = 2 * (longint'(y) * w + x0);
                        if (off + 2 * n - 1 >= STORE_BYTES_DEF)
                            res.st = ST_OUTSIDE;
                        else
                        begin
                            res.val = c;
                            for (int i = 0; i < n; i++)
                            begin
                                frame_mem[off + 2 * i] = c[7:0];
                                frame_mem[off + 2 * i + 1] = c[15:8];
                            end
                            res.cnt = n[CNT_W-1:0];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < STORE_BYTES_DEF; i++) frame_mem[i] = 8'd0;
        mismatches = 0;
        pending = 0;
    end

    // Watch configuration, input and output channels
    always @(posedge clk or negedge rst_n)
    begin
        raster_result_t exp_r;
        if (!rst_n)
        begin
            m_width   = '0;
            m_height  = '0;
            m_stride  = '0;
            m_p16     = 1'b0;
            m_key     = '0;
            m_dither  = DITHER_OFF;
            m_blend   = ROP_COPY;
            m_scissor = SCISSOR_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  m_width   = cfg_data[10:0];
                    CFG_FRAME_HEIGHT: m_height  = cfg_data[10:0];
                    CFG_ROW_STRIDE:   m_stride  = cfg_data[11:0];
                    CFG_PIXEL_16BIT:  m_p16     = cfg_data[0];
                    CFG_CHROMA_KEY:   m_key     = cfg_data[16:0];
                    CFG_DITHER:       m_dither  = cfg_data[1:0];
                    CFG_BLEND:        m_blend   = cfg_data[1:0];
                    CFG_SCISSOR:      m_scissor = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result item st=%0d val=%h cnt=%0d",
                                 $realtime, status, stored_value, pixels_written);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (status !== exp_r.st || stored_value !== exp_r.val ||
                        pixels_written !== exp_r.cnt)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result mismatch exp st=%0d val=%h cnt=%0d",
                                     $realtime, exp_r.st, exp_r.val, exp_r.cnt);
                            $display("    got st=%0d val=%h cnt=%0d",
                                     status, stored_value, pixels_written);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(predict_raster(command, int'(pos_x), int'(pos_y),
                                                    int'(span_end_x), pixel_color));
            pending = expected_q.size();
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench top of the pixel raster unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import prou_pkg::*;

    localparam int IDLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 12;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [63:0]               cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      command = CMD_PIXEL;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [COORD_W-1:0] span_end_x = '0;
    logic [COLOR_W-1:0]        pixel_color = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                status;
    logic [COLOR_W-1:0]        stored_value;
    logic [CNT_W-1:0]          pixels_written;
    int                        mismatches;
    int                        pending;

    // Idle percentages of the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    // Shadow values used to shape stimulus
    int          cur_w;
    int          cur_h;
    logic [15:0] cur_key;

    always #5 clk = ~clk;

    pixel_raster_op_unit dut (.*);

    pixel_raster_op_checker checker_i (.*);

    // Receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic set_config(input int w, input int h, input int stride, input logic p16,
                              input logic [16:0] key, input logic [1:0] dith,
                              input logic [1:0] blend, input logic [63:0] sciss);
        write_reg(CFG_FRAME_WIDTH, 64'(w));
        write_reg(CFG_FRAME_HEIGHT, 64'(h));
        write_reg(CFG_ROW_STRIDE, 64'(stride));
        write_reg(CFG_PIXEL_16BIT, 64'(p16));
        write_reg(CFG_CHROMA_KEY, 64'(key));
        write_reg(CFG_DITHER, 64'(dith));
        write_reg(CFG_BLEND, 64'(blend));
        write_reg(CFG_SCISSOR, sciss);
        cfg_we <= 1'b0;
        cur_w = w & 16'h7FF;
        cur_h = h & 16'h7FF;
        cur_key = key[15:0];
        @(negedge clk);
    endtask

    // Send one item; returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input int x, input int y, input int xe,
                             input logic [15:0] color);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pos_x <= x[15:0];
        pos_y <= y[15:0];
        span_end_x <= xe[15:0];
        pixel_color <= color;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Pause the sender until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic int rand_coord(input int lim);
        if ($urandom_range(99) < 5)
            return int'($urandom_range(65535));
        return int'($urandom_range(lim + 8)) - 4;
    endfunction

    task automatic send_random();
        logic        cmd;
        int          x;
        int          y;
        int          xe;
        logic [15:0] color;
        int          r;
        cmd = ($urandom_range(99) < 30) ? CMD_FILL : CMD_PIXEL;
        x = rand_coord(cur_w);
        y = rand_coord(cur_h);
        r = $urandom_range(99);
        if (r < 5)
            xe = int'($urandom_range(65535));
        else if (r < 8)
        begin
            x = -5;
            xe = cur_w + 5;
        end
        else
            xe = x + int'($urandom_range(20)) - 2;
        color = ($urandom_range(99) < 15) ? cur_key : 16'($urandom_range(65535));
        send_item(cmd, x, y, xe, color);
    endtask

    initial
    begin
        logic [63:0] sc;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: frame, scissor, key, dither and fill clipping
        set_config(64, 32, 80, 1'b0, 17'h1_00A5, DITHER_2X2, ROP_COPY,
                   {16'd20, 16'd40, 16'd2, 16'd4});
        send_item(CMD_PIXEL, -1, 5, 0, 16'h0011);
        send_item(CMD_PIXEL, 5, -1, 0, 16'h0022);
        send_item(CMD_PIXEL, 64, 5, 0, 16'h0033);
        send_item(CMD_PIXEL, 5, 32, 0, 16'h0044);
        send_item(CMD_PIXEL, 3, 5, 0, 16'h0055);
        send_item(CMD_PIXEL, 5, 25, 0, 16'h0066);
        send_item(CMD_PIXEL, 10, 10, 0, 16'hFFA5);
        send_item(CMD_PIXEL, 10, 10, 0, 16'h00FF);
        send_item(CMD_PIXEL, 11, 11, 0, 16'h0000);
        send_item(CMD_PIXEL, 40, 20, 0, 16'h1234);
        send_item(CMD_PIXEL, 32767, 32767, 32767, 16'hFFFF);
        send_item(CMD_PIXEL, -32768, -32768, -32768, 16'h0000);
        send_item(CMD_FILL, 10, 5, 9, 16'h00C3);
        send_item(CMD_FILL, -10, 5, 100, 16'h005A);
        send_item(CMD_FILL, 0, 5, 2, 16'h0077);
        send_item(CMD_FILL, 0, 25, 60, 16'h0088);
        send_item(CMD_FILL, 5, 40, 10, 16'h0099);
        drain();

        // Directed: store bounds and the fourth dither code
        set_config(1024, 1024, 2048, 1'b0, 17'h0_0000, 2'd3, ROP_AND, SCISSOR_RESET);
        send_item(CMD_PIXEL, 0, 100, 0, 16'h00FF);
        send_item(CMD_FILL, 0, 63, 1023, 16'h00E7);
        send_item(CMD_FILL, 0, 64, 5, 16'h0011);
        send_item(CMD_PIXEL, 5, 5, 0, 16'h00FF);
        send_item(CMD_PIXEL, 5, 63, 0, 16'h0F0F);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 10; ph++)
        begin
            sc = {16'($urandom_range(300)), 16'($urandom_range(300)),
                  16'($urandom_range(40)), 16'($urandom_range(40))};
            case (ph)
                0: set_config(64, 48, 64, 1'b0, 17'h0_0000, DITHER_OFF, ROP_COPY, SCISSOR_RESET);
                1: set_config(100, 60, 128, 1'b0, 17'h1_0049, DITHER_2X2, ROP_XOR,
                              {16'd50, 16'd90, 16'd5, 16'd10});
                2: set_config(256, 256, 0, 1'b1, 17'h1_F81F, 2'd2, ROP_OR, SCISSOR_RESET);
                3: set_config(1024, 1024, 2048, 1'b0, 17'h0_00FF, 2'd3, ROP_AND, sc);
                4: set_config(1024, 1024, 100, 1'b1, 17'h1_FFFF, DITHER_2X2, ROP_COPY,
                              {16'd1023, 16'd1023, 16'd0, 16'd0});
                5: set_config(0, 0, 0, 1'b0, 17'h1_0000, DITHER_OFF, ROP_COPY, 64'd0);
                6: set_config(200, 150, 4095, 1'b0, 17'h1_00FF, 2'd2, ROP_OR, '1);
                7: set_config(333, 97, 0, 1'b0, 17'h1_00FF, DITHER_OFF, ROP_XOR, 64'd0);
                default: set_config(int'($urandom_range(2047)), int'($urandom_range(300)),
                                    int'($urandom_range(4095)), 1'($urandom_range(1)),
                                    17'($urandom_range(131071)), 2'($urandom_range(3)),
                                    2'($urandom_range(3)), {$urandom, $urandom});
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_random();
            drain();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
